// File: hdl/zfe_pkg.sv
`timescale 1ns / 1ps

package zfe_pkg;

    localparam int          EPS_WIDTH = 16;
    localparam logic [15:0] EPS_RESET = 16'd67;

    localparam int NUM_LANES = 2;
    localparam int LANE_RE   = 0;
    localparam int LANE_IM   = 1;

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctrl_t;

endpackage

// File: hdl/zero_forcing_equalizer.sv
`timescale 1ns / 1ps

// One-tap zero-forcing equaliser. Each transfer on the slave side carries a
// channel estimate h and a received sample y; the master side returns
// x = conj(h)*y / (|h|^2 + epsilon) with OUT_FRAC fraction bits, truncated
// toward zero and saturated, and tuser set on saturation or a zero
// denominator (outputs then zero). The pipeline takes one transfer every
// cycle unless a full output register waits on m_tready; its stages are two multiply stages,
// two magnitude and range-check stages, one restoring-division stage per
// quotient bit and the output register. Deasserting m_tready holds the
// whole pipeline. Write epsilon through cfg_we/cfg_wdata only while idle.

module zero_forcing_equalizer #(
    parameter int  SAMPLE_WIDTH = 16,
    parameter int  OUT_FRAC     = 10,
    localparam int IN_TDATA_W   = ((4 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [zfe_pkg::EPS_WIDTH-1:0]   cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_TDATA_W-1:0]           s_tdata,   // chan_re, chan_im, rx_re, rx_im
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_TDATA_W-1:0]          m_tdata,   // eq_re, eq_im
    output logic                            m_tuser    // clipped
);

    import zfe_pkg::*;

    localparam int W = SAMPLE_WIDTH;

    logic [EPS_WIDTH-1:0]           eps_reg;
    logic                           en;
    pipe_ctrl_t                     mul_ctrl, div_ctrl;
    logic                           mul_valid;
    logic [2*W:0]                   den;
    logic [NUM_LANES-1:0][2*W:0]    num;
    logic [NUM_LANES-1:0][W-1:0]    eq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            eps_reg <= cfg_wdata;
        end
    end

    // Advance while the output register is empty or being drained
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign mul_ctrl = '{en: en, valid: s_tvalid};

    zfe_cmul #(
        .W (W)
    ) u_cmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl_in (mul_ctrl),
        .chan_re (s_tdata[W-1:0]),
        .chan_im (s_tdata[2*W-1:W]),
        .rx_re   (s_tdata[3*W-1:2*W]),
        .rx_im   (s_tdata[4*W-1:3*W]),
        .epsilon (eps_reg),
        .valid   (mul_valid),
        .den     (den),
        .num     (num)
    );

    assign div_ctrl = '{en: en, valid: mul_valid};

    zfe_div #(
        .W (W),
        .F (OUT_FRAC)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl_in (div_ctrl),
        .den     (den),
        .num     (num),
        .valid   (m_tvalid),
        .eq      (eq),
        .clipped (m_tuser)
    );

    assign m_tdata = OUT_TDATA_W'({eq[LANE_IM], eq[LANE_RE]});

endmodule

// File: hdl/zfe_cmul.sv
`timescale 1ns / 1ps

module zfe_cmul #(
    parameter int W = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  zfe_pkg::pipe_ctrl_t                ctrl_in,
    input  logic signed [W-1:0]                chan_re,
    input  logic signed [W-1:0]                chan_im,
    input  logic signed [W-1:0]                rx_re,
    input  logic signed [W-1:0]                rx_im,
    input  logic [zfe_pkg::EPS_WIDTH-1:0]      epsilon,
    output logic                               valid,
    output logic [2*W:0]                       den,
    output logic [zfe_pkg::NUM_LANES-1:0][2*W:0] num
);

    import zfe_pkg::*;

    localparam int PW = 2 * W;
    localparam int DW = 2 * W + 1;

    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ryr_reg, p_iyi_reg, p_ryi_reg, p_iyr_reg;
    logic signed [PW-1:0] p_rr_next, p_ii_next, p_ryr_next, p_iyi_next, p_ryi_next, p_iyr_next;
    logic                 valid1_reg, valid2_reg;
    logic [DW-1:0]        den_reg, den_next;
    logic signed [PW:0]   nre_reg, nim_reg, nre_next, nim_next;

    // Stage one: six products
    always_comb
    begin
        p_rr_next  = chan_re * chan_re;
        p_ii_next  = chan_im * chan_im;
        p_ryr_next = chan_re * rx_re;
        p_iyi_next = chan_im * rx_im;
        p_ryi_next = chan_re * rx_im;
        p_iyr_next = chan_im * rx_re;
    end

    // Stage two: energy plus regulariser, conj(h)*y
    always_comb
    begin
        den_next = DW'($unsigned(p_rr_reg)) + DW'($unsigned(p_ii_reg)) + DW'(epsilon);
        nre_next = (PW+1)'(p_ryr_reg) + (PW+1)'(p_iyi_reg);
        nim_next = (PW+1)'(p_ryi_reg) - (PW+1)'(p_iyr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (ctrl_in.en)
        begin
            valid1_reg <= ctrl_in.valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_in.en)
        begin
            p_rr_reg  <= p_rr_next;
            p_ii_reg  <= p_ii_next;
            p_ryr_reg <= p_ryr_next;
            p_iyi_reg <= p_iyi_next;
            p_ryi_reg <= p_ryi_next;
            p_iyr_reg <= p_iyr_next;
            den_reg   <= den_next;
            nre_reg   <= nre_next;
            nim_reg   <= nim_next;
        end
    end

    assign valid        = valid2_reg;
    assign den          = den_reg;
    assign num[LANE_RE] = nre_reg;
    assign num[LANE_IM] = nim_reg;

endmodule

// File: hdl/zfe_div.sv
`timescale 1ns / 1ps

module zfe_div #(
    parameter int W = 16,
    parameter int F = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  zfe_pkg::pipe_ctrl_t                    ctrl_in,
    input  logic [2*W:0]                           den,
    input  logic [zfe_pkg::NUM_LANES-1:0][2*W:0]   num,
    output logic                                   valid,
    output logic [zfe_pkg::NUM_LANES-1:0][W-1:0]   eq,
    output logic                                   clipped
);

    import zfe_pkg::*;

    localparam int MW = 2 * W;
    localparam int DW = 2 * W + 1;
    localparam int RW = (2 * W + F > W + DW) ? 2 * W + F : W + DW;
    localparam logic [W-1:0] HALF = W'(1) << (W - 1);

    // Magnitude stage
    logic                           a_valid_reg;
    logic [NUM_LANES-1:0][MW-1:0]   a_mag_reg, a_mag_next;
    logic [NUM_LANES-1:0]           a_neg_reg, a_neg_next;
    logic [DW-1:0]                  a_den_reg;
    logic                           a_dz_reg;

    // Division stages, index 0 is after the overflow check
    logic                           valid_reg [0:W];
    logic [NUM_LANES-1:0][RW-1:0]   r_reg     [0:W-1];
    logic [NUM_LANES-1:0][W-1:0]    q_reg     [0:W];
    logic [NUM_LANES-1:0]           neg_reg   [0:W];
    logic [NUM_LANES-1:0]           ovf_reg   [0:W];
    logic [DW-1:0]                  den_reg   [0:W-1];
    logic                           dz_reg    [0:W];

    logic [NUM_LANES-1:0][RW-1:0]   r0_next;
    logic [NUM_LANES-1:0]           ovf0_next;

    // Output stage
    logic                           o_valid_reg;
    logic [NUM_LANES-1:0][W-1:0]    o_eq_reg, o_eq_next;
    logic                           o_clip_reg, o_clip_next;

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            a_neg_next[l] = num[l][MW];
            a_mag_next[l] = num[l][MW] ? MW'(~num[l] + (MW+1)'(1)) : num[l][MW-1:0];
        end
    end

    // Quotient must stay below 2^W, otherwise it saturates
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            r0_next[l]   = RW'(a_mag_reg[l]) << F;
            ovf0_next[l] = r0_next[l] >= (RW'(a_den_reg) << W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            valid_reg[0] <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (ctrl_in.en)
        begin
            a_valid_reg  <= ctrl_in.valid;
            valid_reg[0] <= a_valid_reg;
            o_valid_reg  <= valid_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_in.en)
        begin
            a_mag_reg  <= a_mag_next;
            a_neg_reg  <= a_neg_next;
            a_den_reg  <= den;
            a_dz_reg   <= (den == '0);
            r_reg[0]   <= r0_next;
            q_reg[0]   <= '0;
            neg_reg[0] <= a_neg_reg;
            ovf_reg[0] <= ovf0_next;
            den_reg[0] <= a_den_reg;
            dz_reg[0]  <= a_dz_reg;
            o_eq_reg   <= o_eq_next;
            o_clip_reg <= o_clip_next;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 1; k <= W; k++)
    begin : g_step
        localparam int B = W - k;

        logic [NUM_LANES-1:0][DW+1:0] diff;
        logic [NUM_LANES-1:0][RW-1:0] r_next;
        logic [NUM_LANES-1:0][W-1:0]  q_next;

        always_comb
        begin
            r_next = r_reg[k-1];
            q_next = q_reg[k-1];
            for (int l = 0; l < NUM_LANES; l++)
            begin
                diff[l] = {1'b0, r_reg[k-1][l][B +: DW+1]} - {2'b00, den_reg[k-1]};
                if (!diff[l][DW+1])
                begin
                    r_next[l][B +: DW+1] = diff[l][DW:0];
                    q_next[l][B]         = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (ctrl_in.en)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl_in.en)
            begin
                q_reg[k]   <= q_next;
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                dz_reg[k]  <= dz_reg[k-1];
            end
        end

        if (k < W)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (ctrl_in.en)
                begin
                    r_reg[k]   <= r_next;
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    // Saturate, restore sign, force zero on an empty denominator
    always_comb
    begin
        logic [NUM_LANES-1:0]        sat;
        logic [NUM_LANES-1:0][W-1:0] mag;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            if (neg_reg[W][l])
            begin
                sat[l] = ovf_reg[W][l] || (q_reg[W][l] > HALF);
                mag[l] = sat[l] ? HALF : q_reg[W][l];
                o_eq_next[l] = (~mag[l]) + W'(1);
            end
            else
            begin
                sat[l] = ovf_reg[W][l] || q_reg[W][l][W-1];
                mag[l] = sat[l] ? (HALF - W'(1)) : q_reg[W][l];
                o_eq_next[l] = mag[l];
            end
            if (dz_reg[W])
            begin
                o_eq_next[l] = '0;
            end
        end
        o_clip_next = dz_reg[W] || (|sat);
    end

    assign valid   = o_valid_reg;
    assign eq      = o_eq_reg;
    assign clipped = o_clip_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import zfe_pkg::*;

    localparam int SW          = 16;
    localparam int OUT_FRAC    = 10;
    localparam int LATENCY     = SW + 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED  = 22;
    localparam int N_PHASES    = 4;
    localparam int PHASE_ITEMS = 475;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [SW-1:0] rx_im;
        logic signed [SW-1:0] rx_re;
        logic signed [SW-1:0] ch_im;
        logic signed [SW-1:0] ch_re;
    } subcarrier_t;

    typedef struct packed {
        logic                 clipped;
        logic signed [SW-1:0] eq_im;
        logic signed [SW-1:0] eq_re;
    } equalized_t;

    typedef struct {
        int ch_re;
        int ch_im;
        int rx_re;
        int rx_im;
        int eps;
        bit typed;
        int e_re;
        int e_im;
        int e_clip;
    } directed_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [EPS_WIDTH-1:0] cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [4*SW-1:0]      s_tdata   = '0;    // chan_re, chan_im, rx_re, rx_im
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [2*SW-1:0]      m_tdata;           // eq_re, eq_im
    logic                 m_tuser;           // clipped

    logic [EPS_WIDTH-1:0] eps_model = EPS_RESET;
    equalized_t           eq_pending [$];
    int                   mismatches    = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    longint               cycles        = 0;

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{0, 0, 0, 0, 67, 1'b1, 0, 0, 0},
        '{0, 0, 32767, -32768, 67, 1'b1, 0, 0, 0},
        '{8192, 0, 8192, 0, 67, 1'b0, 0, 0, 0},
        '{32767, 32767, 32767, 32767, 67, 1'b0, 0, 0, 0},
        '{-32768, -32768, -32768, 32767, 67, 1'b0, 0, 0, 0},
        '{1, 0, 32767, 0, 67, 1'b1, 32767, 0, 1},
        '{1, 0, -32768, 0, 67, 1'b1, -32768, 0, 1},
        '{0, 1, 0, 32767, 67, 1'b1, 32767, 0, 1},
        '{0, -1, 32767, 0, 67, 1'b1, 0, 32767, 1},
        '{-32768, 0, -1, -1, 67, 1'b0, 0, 0, 0},
        '{4096, -2048, 1000, -3000, 67, 1'b0, 0, 0, 0},
        '{-1, -1, -32768, -32768, 67, 1'b1, 32767, 0, 1},
        '{0, 0, 0, 0, 0, 1'b1, 0, 0, 1},
        '{0, 0, 32767, -32768, 0, 1'b1, 0, 0, 1},
        '{8192, 0, 8192, 0, 0, 1'b1, 1024, 0, 0},
        '{-32768, 0, -32768, 0, 0, 1'b1, 1024, 0, 0},
        '{0, 8192, 0, -8192, 0, 1'b1, -1024, 0, 0},
        '{1, 0, -32768, 32767, 0, 1'b1, -32768, 32767, 1},
        '{-32768, -32768, 32767, 32767, 0, 1'b0, 0, 0, 0},
        '{0, 0, 100, 100, 65535, 1'b1, 0, 0, 0},
        '{1, 1, 32767, 32767, 65535, 1'b0, 0, 0, 0},
        '{32767, -32768, -32768, 32767, 65535, 1'b0, 0, 0, 0}
    };

    zero_forcing_equalizer #(
        .SAMPLE_WIDTH (SW),
        .OUT_FRAC     (OUT_FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint scaled_quotient(input longint num, input longint den,
                                               inout bit sat);
        longint mag;
        longint lim;
        longint q;
        mag = (num < 0) ? -num : num;
        lim = (num < 0) ? (longint'(1) <<< (SW - 1)) : (longint'(1) <<< (SW - 1)) - 1;
        q   = (mag <<< OUT_FRAC) / den;
        if (q > lim)
        begin
            sat = 1'b1;
            q   = lim;
        end
        return (num < 0) ? -q : q;
    endfunction

    function automatic equalized_t equalize(input subcarrier_t s,
                                            input logic [EPS_WIDTH-1:0] eps);
        longint     hr;
        longint     hi;
        longint     yr;
        longint     yi;
        longint     den;
        longint     part;
        bit         sat;
        equalized_t r;
        hr  = $signed(s.ch_re);
        hi  = $signed(s.ch_im);
        yr  = $signed(s.rx_re);
        yi  = $signed(s.rx_im);
        den = hr * hr + hi * hi + longint'(eps);
        sat = 1'b0;
        r   = '0;
        if (den == 0)
        begin
            sat = 1'b1;
        end
        else
        begin
            part    = scaled_quotient(hr * yr + hi * yi, den, sat);
            r.eq_re = part[SW-1:0];
            part    = scaled_quotient(hr * yi - hi * yr, den, sat);
            r.eq_im = part[SW-1:0];
        end
        r.clipped = sat;
        return r;
    endfunction

    function automatic logic [SW-1:0] pick_extreme();
        case ($urandom_range(4))
            0:       return {1'b1, {(SW-1){1'b0}}};
            1:       return {SW{1'b1}};
            2:       return '0;
            3:       return {{(SW-1){1'b0}}, 1'b1};
            default: return {1'b0, {(SW-1){1'b1}}};
        endcase
    endfunction

    function automatic subcarrier_t random_subcarrier();
        int          kind;
        subcarrier_t s;
        kind = $urandom_range(99);
        s    = {$urandom, $urandom};
        if (kind >= 50 && kind < 70)
        begin
            // tiny channel: drive the quotient into saturation
            s.ch_re = SW'(int'($urandom_range(32)) - 16);
            s.ch_im = SW'(int'($urandom_range(32)) - 16);
        end
        else if (kind >= 70 && kind < 80)
        begin
            s.ch_re = '0;
            s.ch_im = '0;
        end
        else if (kind >= 80 && kind < 90)
        begin
            s.ch_re = pick_extreme();
            s.ch_im = pick_extreme();
            s.rx_re = pick_extreme();
            s.rx_im = pick_extreme();
        end
        else if (kind >= 90)
        begin
            s.ch_re = SW'(int'($urandom_range(4095)) - 2048);
            s.ch_im = SW'(int'($urandom_range(4095)) - 2048);
        end
        return s;
    endfunction

    task automatic send_subcarrier(input subcarrier_t s, input bit typed,
                                   input equalized_t typed_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        eq_pending.push_back(typed ? typed_res : equalize(s, eps_model));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (eq_pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_epsilon(input logic [EPS_WIDTH-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        eps_model = value;
    endtask

    task automatic report_mismatch(input string what, input equalized_t want,
                                   input equalized_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch, %s: expected re=%0d im=%0d clip=%0b, got re=%0d im=%0d clip=%0b",
                     what, $signed(want.eq_re), $signed(want.eq_im), want.clipped,
                     $signed(got.eq_re), $signed(got.eq_im), got.clipped);
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        equalized_t got;
        equalized_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata};
            if (eq_pending.size() == 0)
            begin
                report_mismatch("transfer with nothing pending", '0, got);
            end
            else
            begin
                want = eq_pending.pop_front();
                if (got.eq_re !== want.eq_re)
                    report_mismatch("eq_re", want, got);
                else if (got.eq_im !== want.eq_im)
                    report_mismatch("eq_im", want, got);
                else if (got.clipped !== want.clipped)
                    report_mismatch("clipped", want, got);
            end
        end
    end

    initial
    begin
        directed_row_t row;
        subcarrier_t   s;
        equalized_t    res;
        send_idle_pct = 25;
        recv_idle_pct = 65;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = directed_rows[i];
            if (row.eps != int'(eps_model))
                write_epsilon(row.eps[EPS_WIDTH-1:0]);
            s.ch_re     = row.ch_re[SW-1:0];
            s.ch_im     = row.ch_im[SW-1:0];
            s.rx_re     = row.rx_re[SW-1:0];
            s.rx_im     = row.rx_im[SW-1:0];
            res.eq_re   = row.e_re[SW-1:0];
            res.eq_im   = row.e_im[SW-1:0];
            res.clipped = row.e_clip[0];
            send_subcarrier(s, row.typed, res);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    write_epsilon({EPS_WIDTH{1'b1}});
                    send_idle_pct = 25;
                    recv_idle_pct = 65;
                end
                1:
                begin
                    write_epsilon(EPS_WIDTH'($urandom_range(65535)));
                    send_idle_pct = 65;
                    recv_idle_pct = 25;
                end
                2:
                begin
                    write_epsilon('0);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                default:
                begin
                    write_epsilon(EPS_WIDTH'($urandom_range(255)));
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_subcarrier(random_subcarrier(), 1'b0, '0);
        end

        drain();
        repeat (LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/zfe_pkg.sv
hdl/zfe_cmul.sv
hdl/zfe_div.sv
hdl/zero_forcing_equalizer.sv
tb/testbench.sv
